@@ src/bia_pkg.sv @@
// Shared constants, codes and types of the bitmap ID allocator.
package bia_pkg;

  localparam int POOL_SIZE = 1024;
  localparam int WORD_W    = 32;
  localparam int NUM_WORDS = POOL_SIZE / WORD_W;
  localparam int ROW_W     = $clog2(NUM_WORDS);
  localparam int BIT_W     = $clog2(WORD_W);
  localparam int ID_W      = 10;
  localparam int COUNT_W   = 11;
  localparam int TYPE_W    = 2;
  localparam int STATUS_W  = 2;

  localparam logic [TYPE_W-1:0] REQ_ALLOC = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_FREE  = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_QUERY = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_USED = 2'd2;

  typedef struct packed {
    logic             rd_en;
    logic [ROW_W-1:0] rd_addr;
    logic             wr_en;
    logic [ROW_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;
  } bia_mem_req_t;

endpackage

@@ src/bia_ffz.sv @@
// Shared find-first-zero unit: lowest clear bit of one word.
module bia_ffz (
  input  logic [bia_pkg::WORD_W-1:0] word,
  output logic                       found,
  output logic [bia_pkg::BIT_W-1:0]  index
);
  import bia_pkg::*;

  always_comb begin
    found = 1'b0;
    index = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!word[i]) begin
        found = 1'b1;
        index = BIT_W'(i);
      end
    end
  end

endmodule

@@ src/bia_mem.sv @@
// Used-bitmap word memory with per-row valid bits and a full-word summary.
module bia_mem (
  input  logic                         clk,
  input  logic                         rst,
  input  bia_pkg::bia_mem_req_t        req,
  output logic [bia_pkg::WORD_W-1:0]   rd_data,
  output logic [bia_pkg::NUM_WORDS-1:0] full_map
);
  import bia_pkg::*;

  logic [WORD_W-1:0]    mem [NUM_WORDS];
  logic [NUM_WORDS-1:0] row_valid;
  logic [WORD_W-1:0]    rd_q;
  logic                 rd_valid;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_q <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      full_map  <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (req.wr_en) begin
        row_valid[req.wr_addr] <= 1'b1;
        full_map[req.wr_addr]  <= &req.wr_data;
      end
      if (req.rd_en) begin
        rd_valid <= row_valid[req.rd_addr];
      end
    end
  end

  // A row never written reads as all free.
  assign rd_data = rd_valid ? rd_q : '0;

endmodule

@@ src/bitmap_id_allocator.sv @@
// Flow: the row is read on accept, then the update step writes the row back
//   and loads the registered response word.
// A new request is taken only after the update step, as the single memory
//   read port and the one find-first-zero unit (once on the summary, once on
//   the word) serve both. Response stall holds update until the slot drains.
// Reset (rst, synchronous): every ID free, count zero, no response pending.
module bitmap_id_allocator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [bia_pkg::TYPE_W-1:0]    req_type,
  input  logic [bia_pkg::ID_W-1:0]      id,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [bia_pkg::ID_W-1:0]      granted_id,
  output logic                          is_used,
  output logic [bia_pkg::STATUS_W-1:0]  status,
  output logic [bia_pkg::COUNT_W-1:0]   in_use_count
);
  import bia_pkg::*;

  // Two-step sequencer: IDLE accepts a word and reads the memory row,
  // UPDATE modifies the row, writes it back and loads the response.
  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_UPDATE = 2'b10
  } state_t;

  state_t             state;
  state_t             state_next;
  logic [TYPE_W-1:0]  op;
  logic [BIT_W-1:0]   bit_id;
  logic [ROW_W-1:0]   row;
  logic               alloc_full;
  logic [COUNT_W-1:0] used_count;

  bia_mem_req_t         mem_req;
  logic [WORD_W-1:0]    rd_data;
  logic [NUM_WORDS-1:0] full_map;

  // Shared find-first-zero unit: summary in IDLE, row word in UPDATE.
  logic [WORD_W-1:0] ffz_word;
  logic              ffz_found;
  logic [BIT_W-1:0]  ffz_index;

  logic accept;
  logic advance;
  logic [ROW_W-1:0]  row_sel;
  logic [BIT_W-1:0]  bit_sel;
  logic [WORD_W-1:0] bit_mask;
  logic              bit_set;

  bia_mem u_mem (
    .clk      (clk),
    .rst      (rst),
    .req      (mem_req),
    .rd_data  (rd_data),
    .full_map (full_map)
  );

  bia_ffz u_ffz (
    .word  (ffz_word),
    .found (ffz_found),
    .index (ffz_index)
  );

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  // Commit the update only when the response slot is free or draining.
  assign advance   = (state == S_UPDATE) && (!rsp_valid || !rsp_stall);

  always_comb begin
    ffz_word = '0;
    if (state == S_IDLE) begin
      ffz_word[NUM_WORDS-1:0] = full_map;
      for (int i = NUM_WORDS; i < WORD_W; i++) begin
        ffz_word[i] = 1'b1;
      end
    end else begin
      ffz_word = rd_data;
    end
  end

  // Pick the row: first non-full row for allocate, the ID's row otherwise.
  assign row_sel  = (req_type == REQ_ALLOC) ? ROW_W'(ffz_index) : id[ID_W-1 -: ROW_W];
  assign bit_sel  = (op == REQ_ALLOC) ? ffz_index : bit_id;
  assign bit_mask = WORD_W'(1) << bit_sel;
  assign bit_set  = |(rd_data & bit_mask);

  always_comb begin
    mem_req         = '0;
    mem_req.rd_en   = accept;
    mem_req.rd_addr = row_sel;
    mem_req.wr_addr = row;
    if (advance) begin
      case (op)
        REQ_ALLOC: begin
          mem_req.wr_en   = !alloc_full;
          mem_req.wr_data = rd_data | bit_mask;
        end
        REQ_FREE: begin
          mem_req.wr_en   = bit_set;
          mem_req.wr_data = rd_data & ~bit_mask;
        end
        default: begin
          mem_req.wr_en   = 1'b0;
          mem_req.wr_data = rd_data;
        end
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (accept) state_next = S_UPDATE;
      S_UPDATE: if (advance) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      used_count <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (advance) begin
        rsp_valid <= 1'b1;
        if (op == REQ_ALLOC && !alloc_full) begin
          used_count <= used_count + COUNT_W'(1);
        end else if (op == REQ_FREE && bit_set) begin
          used_count <= used_count - COUNT_W'(1);
        end
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Latch the request and the summary search result on accept.
  always_ff @(posedge clk) begin
    if (accept) begin
      op         <= req_type;
      bit_id     <= id[BIT_W-1:0];
      row        <= row_sel;
      alloc_full <= !ffz_found;
    end
  end

  // Load the response word.
  always_ff @(posedge clk) begin
    if (advance) begin
      granted_id   <= '0;
      is_used      <= 1'b0;
      status       <= ST_OK;
      in_use_count <= used_count;
      case (op)
        REQ_ALLOC: begin
          if (alloc_full) begin
            status <= ST_FULL;
          end else begin
            granted_id   <= ID_W'({row, bit_sel});
            in_use_count <= used_count + COUNT_W'(1);
          end
        end
        REQ_FREE: begin
          if (bit_set) begin
            in_use_count <= used_count - COUNT_W'(1);
          end else begin
            status <= ST_NOT_USED;
          end
        end
        REQ_QUERY: is_used <= bit_set;
        default: ;
      endcase
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    used_count <= COUNT_W'(POOL_SIZE))
    else $error("in-use count exceeds pool size");

  a_accept_to_update: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_UPDATE))
    else $error("accepted word did not reach update step");

  a_alloc_row_has_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPDATE && op == REQ_ALLOC && !alloc_full) |-> ffz_found)
    else $error("summary pointed at a full row");

  a_full_means_count: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status == ST_FULL) |-> (in_use_count == COUNT_W'(POOL_SIZE)))
    else $error("pool full reported with free IDs left");
`endif

endmodule
